>>> design/ibargb_pkg.sv
// Package for the indexed bitmap to A1R5G5B5 unpacker.
// Holds size limits, mode and register codes, palette port types and the color conversion.
// No dependencies.
package ibargb_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PALETTE_DEPTH = 256;

  localparam int DIM_W  = 13;
  localparam int ADDR_W = 24;
  localparam int PIX_W  = 16;
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  // Pixel mode codes; code 3 falls back to 8 bits per pixel
  localparam logic [1:0] MODE_1BPP     = 2'd0;
  localparam logic [1:0] MODE_4BPP     = 2'd1;
  localparam logic [1:0] MODE_8BPP     = 2'd2;
  localparam logic [1:0] MODE_8BPP_ALT = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_PIXEL_MODE   = 3'd0;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_ROW_PADDING  = 3'd3;
  localparam logic [2:0] CFG_FLIP_ROWS    = 3'd4;

  localparam logic [PIX_W-1:0] PIX_MONO_SET   = 16'hFFFF;
  localparam logic [PIX_W-1:0] PIX_MONO_CLEAR = 16'h8000;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

  // X8R8G8B8 to A1R5G5B5: force alpha, keep the top 5 bits of each channel
  function automatic logic [PIX_W-1:0] to_argb1555(input logic [31:0] c);
    return {1'b1, c[23:19], c[15:11], c[7:3]};
  endfunction

  // Zero reads as one, anything above the limit saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > mx) begin
      r = mx;
    end
    return r;
  endfunction

endpackage

>>> design/ibargb_pal_ram.sv
// Palette store: one write port, one read port, registered read data.
// Depends on ibargb_pkg for depth, widths and port structs.
module ibargb_pal_ram import ibargb_pkg::*; (
  input  logic             clk_i,
  input  pal_wr_t          wr_i,
  input  pal_rd_t          rd_i,
  output logic [PIX_W-1:0] rd_data_o
);

  logic [PIX_W-1:0] mem [PALETTE_DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  // Read-first: a read and a write at the same edge return the old entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/indexed_bitmap_to_argb1555.sv
// A data byte passes the unpack register, the lookup stage and the output register
// before its first pixel shows. While the output is not stalled, 8-bit mode takes one
// byte per cycle, 4-bit and 1-bit modes one pixel per cycle, set by the single palette
// read port and one output pixel per cycle; a row end drops the rest of a byte. Palette
// writes bypass the unpack stage, padding bytes leave it without a lookup. Reset clears
// counters and restores register defaults; the palette holds garbage until written, no clearing pass.
module indexed_bitmap_to_argb1555 import ibargb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        palette_index_i,
  input  logic [31:0]       palette_color_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PIX_W-1:0]  pixel_value_o,
  output logic [ADDR_W-1:0] pixel_address_o,
  output logic              row_end_o,
  output logic              frame_end_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [DIM_W-1:0]  cfg_data_i
);

  localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

  // Configuration registers (sizes stored already clamped)
  logic [1:0]       mode_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [7:0]       pad_cfg_q;
  logic             flip_q;

  // Unpack stage: the byte being split into pixels
  logic             u_valid_q;
  logic [7:0]       sh_q;
  logic [2:0]       left_q;

  // Position counters
  logic [DIM_W-1:0] col_q, row_q;
  logic [7:0]       pad_cnt_q;
  logic             in_pad_q;

  // Lookup stage: palette read in flight
  logic             s1_valid_q;
  logic             s1_mono_q, s1_bit_q, s1_oob_q;
  logic [DIM_W-1:0] s1_row_q, s1_col_q;
  logic             s1_rend_q, s1_fend_q;

  // Output register
  logic              o_valid_q;
  logic [PIX_W-1:0]  pix_q;
  logic [ADDR_W-1:0] addr_q;
  logic              rend_q, fend_q;

  logic             o_free, s1_free, issue, pad_eat, u_done, last_pix;
  logic             in_acc, data_acc, pal_acc, cfg_acc;
  logic [7:0]       idx;
  logic [DIM_W-1:0] row_sel, dest_row;
  logic             rend, fend;
  logic [2:0]       left_init;
  logic [7:0]       sh_next;
  logic [PIX_W-1:0] rd_data, pix_d;
  pal_wr_t          pal_wr;
  pal_rd_t          pal_rd;

  // Handshakes: the output register frees the pipe as soon as its item leaves
  assign o_free   = !o_valid_q || !out_stall_i;
  assign s1_free  = !s1_valid_q || o_free;
  assign pad_eat  = u_valid_q && in_pad_q;
  assign issue    = u_valid_q && !in_pad_q && s1_free;

  // Pick the current pixel from the top of the shift register
  always_comb begin
    unique case (mode_q)
      MODE_1BPP: begin
        idx       = {7'd0, sh_q[7]};
        sh_next   = {sh_q[6:0], 1'b0};
      end
      MODE_4BPP: begin
        idx       = {4'd0, sh_q[7:4]};
        sh_next   = {sh_q[3:0], 4'd0};
      end
      default: begin
        idx       = sh_q;
        sh_next   = sh_q;
      end
    endcase
  end

  always_comb begin
    unique case (mode_q)
      MODE_1BPP: left_init = 3'd7;
      MODE_4BPP: left_init = 3'd1;
      default:   left_init = 3'd0;
    endcase
  end

  // Rows past the frame height are addressed as the last row
  assign row_sel  = (row_q < height_q) ? row_q : height_q - DIM_W'(1);
  assign dest_row = flip_q ? (height_q - DIM_W'(1) - row_sel) : row_sel;
  assign rend     = ({1'b0, col_q} + (DIM_W+1)'(1)) >= {1'b0, width_q};
  assign fend     = rend && (({1'b0, row_q} + (DIM_W+1)'(1)) >= {1'b0, height_q});

  // Drop the rest of the byte when its row ends
  assign last_pix = (left_q == 3'd0) || rend;
  assign u_done   = pad_eat || (issue && last_pix);

  assign in_stall_o = u_valid_q && !u_done;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign data_acc   = in_acc && !req_type_i;
  assign pal_acc    = in_acc && req_type_i;

  // Hold configuration writes until no byte or pixel is left in the pipe
  assign cfg_ready_o = !u_valid_q && !s1_valid_q && !o_valid_q;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // Palette writes convert on load; they follow every read of earlier bytes
  assign pal_wr.en   = pal_acc && (int'(palette_index_i) < PALETTE_DEPTH);
  assign pal_wr.addr = palette_index_i[PAL_AW-1:0];
  assign pal_wr.data = to_argb1555(palette_color_i);
  assign pal_rd.en   = issue;
  assign pal_rd.addr = idx[PAL_AW-1:0];

  ibargb_pal_ram u_pal_ram (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_i      (pal_rd),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_8BPP;
      width_q   <= DIM_W'(1);
      height_q  <= DIM_W'(1);
      pad_cfg_q <= '0;
      flip_q    <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_PIXEL_MODE:   mode_q    <= cfg_data_i[1:0];
        CFG_IMAGE_WIDTH:  width_q   <= clamp_dim(cfg_data_i, MaxW);
        CFG_IMAGE_HEIGHT: height_q  <= clamp_dim(cfg_data_i, MaxH);
        CFG_ROW_PADDING:  pad_cfg_q <= cfg_data_i[7:0];
        CFG_FLIP_ROWS:    flip_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Unpack stage: load a byte, shift one pixel out per issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q <= 1'b0;
      sh_q      <= '0;
      left_q    <= '0;
    end else if (data_acc) begin
      u_valid_q <= 1'b1;
      sh_q      <= data_byte_i;
      left_q    <= left_init;
    end else if (u_done) begin
      u_valid_q <= 1'b0;
    end else if (issue) begin
      sh_q      <= sh_next;
      left_q    <= left_q - 3'd1;
    end
  end

  // Column, row and padding bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pad_cnt_q <= '0;
      in_pad_q  <= 1'b0;
    end else if (pad_eat) begin
      pad_cnt_q <= pad_cnt_q - 8'd1;
      if (pad_cnt_q == 8'd1) begin
        in_pad_q <= 1'b0;
      end
    end else if (issue) begin
      if (rend) begin
        col_q     <= '0;
        row_q     <= fend ? '0 : row_q + DIM_W'(1);
        pad_cnt_q <= pad_cfg_q;
        in_pad_q  <= (pad_cfg_q != 8'd0);
      end else begin
        col_q <= col_q + DIM_W'(1);
      end
    end
  end

  // Lookup stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (issue) begin
      s1_valid_q <= 1'b1;
    end else if (o_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_mono_q <= (mode_q == MODE_1BPP);
      s1_bit_q  <= idx[0];
      s1_oob_q  <= (int'(idx) >= PALETTE_DEPTH);
      s1_row_q  <= dest_row;
      s1_col_q  <= col_q;
      s1_rend_q <= rend;
      s1_fend_q <= fend;
    end
  end

  // Output register: pick the pixel and form the address
  always_comb begin
    if (s1_mono_q) begin
      pix_d = s1_bit_q ? PIX_MONO_SET : PIX_MONO_CLEAR;
    end else if (s1_oob_q) begin
      pix_d = '0;
    end else begin
      pix_d = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_free) begin
      o_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free && s1_valid_q) begin
      pix_q  <= pix_d;
      addr_q <= ADDR_W'((2*DIM_W)'(s1_row_q) * (2*DIM_W)'(width_q)
                        + (2*DIM_W)'(s1_col_q));
      rend_q <= s1_rend_q;
      fend_q <= s1_fend_q;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign pixel_value_o   = pix_q;
  assign pixel_address_o = addr_q;
  assign row_end_o       = rend_q;
  assign frame_end_o     = fend_q;

endmodule

>>> design/ibargb_checker.sv
// Port-level checks for indexed_bitmap_to_argb1555, attached by bind.
// Depends on ibargb_pkg for widths.
module ibargb_checker import ibargb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PIX_W-1:0]  pixel_value_o,
  input logic [ADDR_W-1:0] pixel_address_o,
  input logic              row_end_o,
  input logic              frame_end_o
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(pixel_address_o) && $stable(row_end_o) && $stable(frame_end_o))
    else $error("stalled result item changed");

  // The last pixel of a frame also closes its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // No result item right out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid at reset release");

  // Input is never stalled right out of reset
  a_reset_ready: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_stall_o)
    else $error("input stalled at reset release");

endmodule

bind indexed_bitmap_to_argb1555 ibargb_checker u_checker (.*);
